[rtl/tmls_pkg.sv]
`timescale 1ns / 1ps

package tmls_pkg;

  localparam int NUM_MODES = 5;

  // Phase wrap point of the motor 1 / motor 3 drive sequence.
  localparam logic [4:0] PHASE_COUNT = 5'd16;

  // Mode codes
  localparam logic [2:0] MODE_STD      = 3'd0;
  localparam logic [2:0] MODE_FAST_ADV = 3'd1;
  localparam logic [2:0] MODE_SLOW_ADV = 3'd2;
  localparam logic [2:0] MODE_SLOW_RET = 3'd3;
  localparam logic [2:0] MODE_REWIND   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE_SELECT   = 2'd0;
  localparam logic [1:0] CFG_M1_MOVE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_M2_RELOAD     = 2'd2;
  localparam logic [1:0] CFG_M2_PPS        = 2'd3;

  // Active motor codes as reported on the result
  localparam logic [1:0] ACT_M3 = 2'd0;
  localparam logic [1:0] ACT_M2 = 2'd1;
  localparam logic [1:0] ACT_M1 = 2'd2;

  typedef enum logic [2:0] {
    SQ_M3 = 3'b001,
    SQ_M2 = 3'b010,
    SQ_M1 = 3'b100
  } seq_t;

  // Per-mode reset values
  localparam seq_t       SEQ_INIT      [NUM_MODES] = '{SQ_M3, SQ_M3, SQ_M3, SQ_M1, SQ_M1};
  localparam logic [4:0] M1_PHASE_INIT [NUM_MODES] = '{5'd6, 5'd0, 5'd0, 5'd16, 5'd16};
  localparam logic [4:0] M3_PHASE_INIT [NUM_MODES] = '{5'd0, 5'd0, 5'd0, 5'd16, 5'd16};
  localparam logic [7:0] MOVE_CNT_INIT [NUM_MODES] = '{8'd0, 8'd1, 8'd1, 8'd0, 8'd0};

  localparam logic [15:0] M2_REMAINING_INIT = 16'd500;
  localparam logic [1:0]  RET_LIMIT_INIT    = 2'd2;
  localparam logic [1:0]  RET_LIMIT_NEXT    = 2'd1;

  localparam logic [2:0]  CFG_MODE_RST   = MODE_STD;
  localparam logic [7:0]  CFG_LIMIT_RST  = 8'd4;
  localparam logic [15:0] CFG_RELOAD_RST = 16'd500;
  localparam logic [7:0]  CFG_PPS_RST    = 8'd8;

  typedef struct packed {
    logic [2:0]  mode_select;
    logic [7:0]  m1_move_limit;
    logic [15:0] m2_move_reload;
    logic [7:0]  m2_pulses_per_step;
  } cfg_t;

  typedef struct packed {
    logic [1:0] active_motor;
    logic       light_on;
    logic       m2_reverse;
    logic       m2_clock_pulse;
    logic       m1_drive_valid;
    logic [7:0] m1_drive;
    logic       m3_drive_valid;
    logic [7:0] m3_drive;
  } res_t;

  function automatic logic [7:0] drive_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h06;
      4'd1:    b = 8'h46;
      4'd2:    b = 8'h06;
      4'd3:    b = 8'h44;
      4'd4:    b = 8'h04;
      4'd5:    b = 8'h44;
      4'd6:    b = 8'h44;
      4'd7:    b = 8'h40;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'h40;
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h42;
      4'd12:   b = 8'h02;
      4'd13:   b = 8'h42;
      4'd14:   b = 8'h42;
      4'd15:   b = 8'h46;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] seq_code(input seq_t s);
    logic [1:0] c;
    case (s)
      SQ_M3:   c = ACT_M3;
      SQ_M2:   c = ACT_M2;
      SQ_M1:   c = ACT_M1;
      default: c = ACT_M3;
    endcase
    return c;
  endfunction

endpackage

[rtl/tmls_phase_step.sv]
`timescale 1ns / 1ps

// One step of a motor phase: forward emits then advances, backward
// retreats (wrapping at zero) then emits.
module tmls_phase_step
  import tmls_pkg::*;
(
  input  logic       fwd,
  input  logic [4:0] phase,
  output logic [4:0] phase_nxt,
  output logic [7:0] drive,
  output logic       wrap
);

  logic [4:0] inc;
  logic [4:0] base;
  logic [4:0] dec;

  always_comb begin
    inc  = phase + 5'd1;
    base = (phase == 5'd0) ? PHASE_COUNT : phase;
    dec  = base - 5'd1;
    if (fwd) begin
      drive     = drive_byte(phase[3:0]);
      wrap      = (inc >= PHASE_COUNT);
      phase_nxt = wrap ? 5'd0 : inc;
    end else begin
      drive     = drive_byte(dec[3:0]);
      wrap      = 1'b0;
      phase_nxt = dec;
    end
  end

endmodule

[rtl/tmls_seq_core.sv]
`timescale 1ns / 1ps

// Per-mode sequence state and the single-tick decision logic.
module tmls_seq_core
  import tmls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic tick_en,
  input  cfg_t cfg,
  input  logic limit_up,
  input  logic limit_down,
  input  logic advance_request,
  output res_t res
);

  seq_t        seq_r       [NUM_MODES];
  logic [4:0]  m1_phase_r  [NUM_MODES];
  logic [4:0]  m3_phase_r  [NUM_MODES];
  logic [7:0]  pulse_cnt_r [NUM_MODES];
  logic [7:0]  move_cnt_r  [NUM_MODES];
  logic [15:0] m2_rem_r;
  logic [1:0]  ret_limit_r;
  logic        lamp_r;

  seq_t        seq_nxt;
  logic [4:0]  m1_phase_nxt;
  logic [4:0]  m3_phase_nxt;
  logic [7:0]  pulse_cnt_nxt;
  logic [7:0]  move_cnt_nxt;
  logic [15:0] m2_rem_nxt;
  logic [1:0]  ret_limit_nxt;
  logic        lamp_nxt;

  logic [2:0]  mode;
  logic        mode_ok;
  logic [2:0]  idx;
  logic        is_fwd;
  seq_t        seq_cur;
  logic [4:0]  p1_cur;
  logic [4:0]  p3_cur;
  logic [7:0]  pc_cur;
  logic [7:0]  mc_cur;

  logic [4:0]  p1_step;
  logic [4:0]  p3_step;
  logic [7:0]  d1_step;
  logic [7:0]  d3_step;
  logic        wrap1;
  logic        wrap3;

  logic [7:0]  cnt_inc;
  logic        m2_expire;
  logic        stop;

  assign mode    = cfg.mode_select;
  assign mode_ok = (mode <= MODE_REWIND);
  assign idx     = mode_ok ? mode : MODE_STD;
  assign is_fwd  = (mode <= MODE_SLOW_ADV);
  assign seq_cur = seq_r[idx];
  assign p1_cur  = m1_phase_r[idx];
  assign p3_cur  = m3_phase_r[idx];
  assign pc_cur  = pulse_cnt_r[idx];
  assign mc_cur  = move_cnt_r[idx];

  tmls_phase_step u_step_m3 (
    .fwd       (is_fwd),
    .phase     (p3_cur),
    .phase_nxt (p3_step),
    .drive     (d3_step),
    .wrap      (wrap3)
  );

  tmls_phase_step u_step_m1 (
    .fwd       (is_fwd),
    .phase     (p1_cur),
    .phase_nxt (p1_step),
    .drive     (d1_step),
    .wrap      (wrap1)
  );

  assign cnt_inc   = pc_cur + 8'd1;
  assign m2_expire = (m2_rem_r == 16'd0);

  always_comb begin
    seq_nxt       = seq_cur;
    m1_phase_nxt  = p1_cur;
    m3_phase_nxt  = p3_cur;
    pulse_cnt_nxt = pc_cur;
    move_cnt_nxt  = mc_cur;
    m2_rem_nxt    = m2_rem_r;
    ret_limit_nxt = ret_limit_r;
    lamp_nxt      = lamp_r;
    stop          = 1'b0;
    res           = '0;

    if (mode_ok) begin
      res.m2_reverse = (mode == MODE_SLOW_RET);
      case (seq_cur)
        SQ_M3: begin
          stop = is_fwd ? limit_up : limit_down;
          if (stop) begin
            seq_nxt = (mode inside {MODE_FAST_ADV, MODE_REWIND}) ? SQ_M1 : SQ_M2;
          end else begin
            res.m3_drive_valid = 1'b1;
            res.m3_drive       = d3_step;
            m3_phase_nxt       = p3_step;
          end
        end
        SQ_M2: begin
          if (mode inside {MODE_STD, MODE_SLOW_ADV, MODE_SLOW_RET}) begin
            stop = (mode == MODE_SLOW_RET) ? limit_up : limit_down;
            if (stop) begin
              if (mode == MODE_STD) begin
                lamp_nxt = 1'b0;
              end
              seq_nxt = SQ_M3;
            end else begin
              if (mode == MODE_STD) begin
                lamp_nxt = 1'b1;
              end
              if (mode != MODE_STD || advance_request) begin
                res.m2_clock_pulse = 1'b1;
                if (!m2_expire) begin
                  // a step is a full group of pulses; zero pulses-per-step
                  // makes every pulse a step
                  if (cnt_inc >= cfg.m2_pulses_per_step) begin
                    pulse_cnt_nxt = 8'd0;
                    m2_rem_nxt    = m2_rem_r - 16'd1;
                  end else begin
                    pulse_cnt_nxt = cnt_inc;
                  end
                end else begin
                  m2_rem_nxt = cfg.m2_move_reload;
                  if (mode != MODE_SLOW_ADV) begin
                    lamp_nxt = 1'b0;
                  end
                  seq_nxt = SQ_M1;
                end
              end
            end
          end
        end
        SQ_M1: begin
          if (mode inside {MODE_STD, MODE_SLOW_ADV}) begin
            if (mc_cur < cfg.m1_move_limit) begin
              res.m1_drive_valid = 1'b1;
              res.m1_drive       = d1_step;
              m1_phase_nxt       = p1_step;
              if (wrap1) begin
                move_cnt_nxt = mc_cur + 8'd1;
              end
            end else begin
              move_cnt_nxt = 8'd0;
              seq_nxt      = SQ_M2;
            end
          end else if (mode == MODE_FAST_ADV) begin
            if (!limit_down) begin
              res.m1_drive_valid = 1'b1;
              res.m1_drive       = d1_step;
              m1_phase_nxt       = p1_step;
              if (wrap1) begin
                move_cnt_nxt = mc_cur + 8'd1;
              end
            end else begin
              seq_nxt = SQ_M3;
            end
          end else if (mode == MODE_SLOW_RET) begin
            if (mc_cur <= {6'd0, ret_limit_r}) begin
              res.m1_drive_valid = 1'b1;
              res.m1_drive       = d1_step;
              m1_phase_nxt       = p1_step;
              if (p1_step == 5'd0) begin
                move_cnt_nxt = mc_cur + 8'd1;
              end
            end else begin
              ret_limit_nxt = RET_LIMIT_NEXT;
              move_cnt_nxt  = 8'd1;
              seq_nxt       = SQ_M2;
            end
          end else begin
            if (!limit_up) begin
              res.m1_drive_valid = 1'b1;
              res.m1_drive       = d1_step;
              m1_phase_nxt       = p1_step;
            end else begin
              seq_nxt = SQ_M3;
            end
          end
        end
        default: begin
          seq_nxt = seq_cur;
        end
      endcase
      res.active_motor = seq_code(seq_nxt);
    end
    res.light_on = lamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MODES; i++) begin
        seq_r[i]       <= SEQ_INIT[i];
        m1_phase_r[i]  <= M1_PHASE_INIT[i];
        m3_phase_r[i]  <= M3_PHASE_INIT[i];
        pulse_cnt_r[i] <= 8'd0;
        move_cnt_r[i]  <= MOVE_CNT_INIT[i];
      end
      m2_rem_r    <= M2_REMAINING_INIT;
      ret_limit_r <= RET_LIMIT_INIT;
      lamp_r      <= 1'b0;
    end else if (tick_en && mode_ok) begin
      seq_r[idx]       <= seq_nxt;
      m1_phase_r[idx]  <= m1_phase_nxt;
      m3_phase_r[idx]  <= m3_phase_nxt;
      pulse_cnt_r[idx] <= pulse_cnt_nxt;
      move_cnt_r[idx]  <= move_cnt_nxt;
      m2_rem_r         <= m2_rem_nxt;
      ret_limit_r      <= ret_limit_nxt;
      lamp_r           <= lamp_nxt;
    end
  end

  // return-mode limit only ever holds its two legal values
  a_ret_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (ret_limit_r == RET_LIMIT_INIT) || (ret_limit_r == RET_LIMIT_NEXT))
    else $error("return move limit out of range");

  // an undefined mode leaves the shared countdown alone
  a_bad_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && !mode_ok) |=> $stable(m2_rem_r) && $stable(lamp_r))
    else $error("undefined mode changed shared state");

endmodule

[rtl/three_motor_limit_switch_sequencer.sv]
`timescale 1ns / 1ps

// Path: an accepted request waits in the input register, then moves into the result register that drives out_tvalid.
// Throughput: one request per cycle while the result side is not stalled; the decision logic is a single pass.
// A stalled result holds in the output register while the input register still takes a request.
// Reset: rst_n synchronous, active low; clears all per-mode state to its initial values
// and the configuration registers to mode 0, limit 4, reload 500, 8 pulses per step.
module three_motor_limit_switch_sequencer
  import tmls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // tick requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] limit_up, [1] limit_down, [2] advance_request
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] m3_drive, [8] m3_drive_valid, [16:9] m1_drive,
                                  // [17] m1_drive_valid, [18] m2_clock_pulse,
                                  // [19] m2_reverse, [20] light_on, [22:21] active_motor
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r;

  // input register
  logic in_v_r;
  logic in_v_nxt;
  logic up_r;
  logic down_r;
  logic req_r;

  // result register
  logic out_v_r;
  logic out_v_nxt;
  res_t out_r;
  res_t res;

  logic in_acc;
  logic adv;

  // The held request moves into the result register whenever that
  // register is empty or is being drained this cycle.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign in_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : in_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_select        <= CFG_MODE_RST;
      cfg_r.m1_move_limit      <= CFG_LIMIT_RST;
      cfg_r.m2_move_reload     <= CFG_RELOAD_RST;
      cfg_r.m2_pulses_per_step <= CFG_PPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE_SELECT:   cfg_r.mode_select        <= cfg_data[2:0];
        CFG_M1_MOVE_LIMIT: cfg_r.m1_move_limit      <= cfg_data[7:0];
        CFG_M2_RELOAD:     cfg_r.m2_move_reload     <= cfg_data;
        CFG_M2_PPS:        cfg_r.m2_pulses_per_step <= cfg_data[7:0];
        default:           cfg_r                    <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_r   <= in_tdata[0];
      down_r <= in_tdata[1];
      req_r  <= in_tdata[2];
    end
    if (adv) begin
      out_r <= res;
    end
  end

  tmls_seq_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .tick_en         (adv),
    .cfg             (cfg_r),
    .limit_up        (up_r),
    .limit_down      (down_r),
    .advance_request (req_r),
    .res             (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r};

  // one motor action per tick at most
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $countones({out_r.m3_drive_valid, out_r.m1_drive_valid,
                            out_r.m2_clock_pulse}) <= 1)
    else $error("more than one motor driven in a tick");

  // drive bytes are zero unless that motor stepped
  a_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.m3_drive_valid || out_r.m3_drive == 8'd0) &&
                (out_r.m1_drive_valid || out_r.m1_drive == 8'd0))
    else $error("drive byte set without a step");

  // active motor code is never the unused value
  a_act_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.active_motor != 2'd3)
    else $error("bad active motor code");

  // a held request is not dropped while the result side stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |=> in_v_r)
    else $error("held request lost");

endmodule

[dv/three_motor_limit_switch_sequencer_test.sv]
`timescale 1ns / 1ps

module three_motor_limit_switch_sequencer_test;
  import tmls_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_TICKS = 1000;
  localparam int LONG_HOLD    = 80;

  // mode_select values outside the five sequences
  localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

  // Drive-byte table, entry 15 in the top byte down to entry 0 in the low byte.
  localparam logic [127:0] DRIVE_BYTES = {
    8'h46, 8'h42, 8'h42, 8'h02, 8'h42, 8'h00, 8'h40, 8'h00,
    8'h40, 8'h44, 8'h44, 8'h04, 8'h44, 8'h06, 8'h46, 8'h06
  };

  // One directed row: register setting, tick bits {advance_request, limit_down, limit_up},
  // and a hand-typed result where it is obvious from the sequence rules.
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  lim;
    logic [15:0] rel;
    logic [7:0]  pps;
    logic [2:0]  tick;
    logic        typed;
    logic [23:0] want;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = 2'd0;
  logic [15:0] cfg_data   = 16'd0;

  // Register copy as last written
  logic [2:0]  mode_r;
  logic [7:0]  limit_r;
  logic [15:0] reload_r;
  logic [7:0]  pps_r;

  // Per-mode sequencer state, shadowing the block
  logic [1:0]  seq_st    [5];
  logic [4:0]  m1_ph     [5];
  logic [4:0]  m3_ph     [5];
  logic [7:0]  pulse_cnt [5];
  logic [7:0]  move_cnt  [5];
  logic [15:0] m2_left;
  logic [1:0]  ret_limit;
  logic        lamp;

  res_t     pending_results [$];
  dir_row_t dir_rows        [$];

  int errors             = 0;
  int results_checked    = 0;
  int countdown_expiries = 0;
  int settings_applied   = 0;
  int random_ticks       = 0;
  int long_holds         = 0;
  int cycles             = 0;
  int send_idle_max      = 5;
  int recv_idle_max      = 5;
  int up_pct, down_pct, req_pct;
  bit long_hold_due      = 1'b0;

  three_motor_limit_switch_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] limit_up, [1] limit_down, [2] advance_request
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] m3_drive, [8] m3_drive_valid, [16:9] m1_drive,
                               // [17] m1_drive_valid, [18] m2_clock_pulse,
                               // [19] m2_reverse, [20] light_on, [22:21] active_motor
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs a handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] drive_at(input logic [4:0] ph);
    return DRIVE_BYTES[{ph[3:0], 3'b000} +: 8];
  endfunction

  // {wrapped, next phase} for a forward step
  function automatic logic [5:0] fwd_next(input logic [4:0] ph);
    logic [4:0] nx;
    nx = ph + 5'd1;
    if (nx >= PHASE_COUNT) return {1'b1, 5'd0};
    return {1'b0, nx};
  endfunction

  // backward step wraps to PHASE_COUNT at zero before the decrement
  function automatic logic [4:0] back_next(input logic [4:0] ph);
    logic [4:0] p;
    p = (ph == 5'd0) ? PHASE_COUNT : ph;
    return p - 5'd1;
  endfunction

  // Advances the shadow state by one tick and returns the result the block owes.
  function automatic res_t sequence_tick(input logic [2:0] bits);
    res_t       r;
    int         m;
    logic       up, down, req, fwd, stop, go;
    logic [5:0] nxt;
    r    = '0;
    up   = bits[0];
    down = bits[1];
    req  = bits[2];
    m    = int'(mode_r);
    if (mode_r <= MODE_REWIND) begin
      fwd          = (mode_r <= MODE_SLOW_ADV);
      r.m2_reverse = (mode_r == MODE_SLOW_RET);
      if (seq_st[m] == ACT_M3) begin
        stop = fwd ? up : down;
        if (stop) begin
          seq_st[m] = (mode_r == MODE_FAST_ADV || mode_r == MODE_REWIND) ? ACT_M1 : ACT_M2;
        end else if (fwd) begin
          r.m3_drive_valid = 1'b1;
          r.m3_drive       = drive_at(m3_ph[m]);
          nxt              = fwd_next(m3_ph[m]);
          m3_ph[m]         = nxt[4:0];
        end else begin
          // return and rewind: byte taken from motor 3's own phase after the step
          r.m3_drive_valid = 1'b1;
          m3_ph[m]         = back_next(m3_ph[m]);
          r.m3_drive       = drive_at(m3_ph[m]);
        end
      end else if (seq_st[m] == ACT_M2 && mode_r != MODE_FAST_ADV && mode_r != MODE_REWIND) begin
        stop = (mode_r == MODE_SLOW_RET) ? up : down;
        if (stop) begin
          if (mode_r == MODE_STD) lamp = 1'b0;
          seq_st[m] = ACT_M3;
        end else begin
          if (mode_r == MODE_STD) lamp = 1'b1;
          if (mode_r != MODE_STD || req) begin
            r.m2_clock_pulse = 1'b1;
            if (m2_left != 16'd0) begin
              pulse_cnt[m] = pulse_cnt[m] + 8'd1;
              if (pulse_cnt[m] >= pps_r) begin
                pulse_cnt[m] = 8'd0;
                m2_left      = m2_left - 16'd1;
              end
            end else begin
              m2_left = reload_r;
              countdown_expiries++;
              if (mode_r != MODE_SLOW_ADV) lamp = 1'b0;
              seq_st[m] = ACT_M1;
            end
          end
        end
      end else if (seq_st[m] == ACT_M1) begin
        case (mode_r)
          MODE_STD, MODE_SLOW_ADV, MODE_FAST_ADV: begin
            go = (mode_r == MODE_FAST_ADV) ? !down : (move_cnt[m] < limit_r);
            if (go) begin
              r.m1_drive_valid = 1'b1;
              r.m1_drive       = drive_at(m1_ph[m]);
              nxt              = fwd_next(m1_ph[m]);
              m1_ph[m]         = nxt[4:0];
              // fast advance count is free running, wraps at 256
              if (nxt[5]) move_cnt[m] = move_cnt[m] + 8'd1;
            end else if (mode_r == MODE_FAST_ADV) begin
              seq_st[m] = ACT_M3;
            end else begin
              move_cnt[m] = 8'd0;
              seq_st[m]   = ACT_M2;
            end
          end
          MODE_SLOW_RET: begin
            if (move_cnt[m] <= {6'd0, ret_limit}) begin
              r.m1_drive_valid = 1'b1;
              m1_ph[m]         = back_next(m1_ph[m]);
              r.m1_drive       = drive_at(m1_ph[m]);
              if (m1_ph[m] == 5'd0) move_cnt[m] = move_cnt[m] + 8'd1;
            end else begin
              // first return move counts from zero to a limit of 2, later ones from one to a limit of 1
              ret_limit   = 2'd1;
              move_cnt[m] = 8'd1;
              seq_st[m]   = ACT_M2;
            end
          end
          MODE_REWIND: begin
            if (!up) begin
              r.m1_drive_valid = 1'b1;
              m1_ph[m]         = back_next(m1_ph[m]);
              r.m1_drive       = drive_at(m1_ph[m]);
            end else begin
              seq_st[m] = ACT_M3;
            end
          end
          default: ;
        endcase
      end
      r.active_motor = seq_st[m];
    end
    r.light_on = lamp;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] mode, input logic [7:0] lim,
                                      input logic [15:0] rel, input logic [7:0] pps,
                                      input logic [2:0] tick, input logic typed,
                                      input logic [23:0] want);
    dir_row_t row;
    row = '{mode, lim, rel, pps, tick, typed, want};
    return row;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offers one tick request after a random gap; predicts it on acceptance.
  // Entered and left at a falling edge.
  task automatic send_tick(input logic [2:0] bits, input logic typed, input logic [23:0] want);
    int   gap;
    res_t predicted;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, bits};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = sequence_tick(bits);
    pending_results.push_back(typed ? res_t'(want[22:0]) : predicted);
    @(negedge clk);
  endtask

  task automatic random_tick();
    logic [2:0] bits;
    bits[0] = ($urandom_range(0, 99) < up_pct);
    bits[1] = ($urandom_range(0, 99) < down_pct);
    bits[2] = ($urandom_range(0, 99) < req_pct);
    send_tick(bits, 1'b0, 24'd0);
    if (mode_r <= MODE_REWIND) random_ticks++;
  endtask

  // Drains the block, then writes all four registers in turn.
  // Noisy writes put junk above the mode, limit and pulses-per-step widths; only the low bits count.
  task automatic apply_setting(input logic [2:0] mode, input logic [7:0] lim,
                               input logic [15:0] rel, input logic [7:0] pps,
                               input bit noisy);
    logic [12:0] mode_junk;
    logic [7:0]  lim_junk, pps_junk;
    mode_junk = noisy ? 13'($urandom) : 13'd0;
    lim_junk  = noisy ? 8'($urandom) : 8'd0;
    pps_junk  = noisy ? 8'($urandom) : 8'd0;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE_SELECT;
    cfg_data  <= {mode_junk, mode};
    @(negedge clk);
    cfg_index <= CFG_M1_MOVE_LIMIT;
    cfg_data  <= {lim_junk, lim};
    @(negedge clk);
    cfg_index <= CFG_M2_RELOAD;
    cfg_data  <= rel;
    @(negedge clk);
    cfg_index <= CFG_M2_PPS;
    cfg_data  <= {pps_junk, pps};
    @(negedge clk);
    cfg_we   <= 1'b0;
    mode_r   = mode;
    limit_r  = lim;
    reload_r = rel;
    pps_r    = pps;
    settings_applied++;
  endtask

  // Result receiver: random hold-off per result, plus one long stall on request
  // from the stimulus so the block backs up into its input.
  initial begin
    int w;
    forever begin
      w = $urandom_range(0, recv_idle_max);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        w = LONG_HOLD;
        long_holds++;
      end
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Scoreboard: every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[22:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("m3_drive", 16'(want.m3_drive), 16'(got.m3_drive));
        check_field("m3_drive_valid", 16'(want.m3_drive_valid), 16'(got.m3_drive_valid));
        check_field("m1_drive", 16'(want.m1_drive), 16'(got.m1_drive));
        check_field("m1_drive_valid", 16'(want.m1_drive_valid), 16'(got.m1_drive_valid));
        check_field("m2_clock_pulse", 16'(want.m2_clock_pulse), 16'(got.m2_clock_pulse));
        check_field("m2_reverse", 16'(want.m2_reverse), 16'(got.m2_reverse));
        check_field("light_on", 16'(want.light_on), 16'(got.light_on));
        check_field("active_motor", 16'(want.active_motor), 16'(got.active_motor));
        check_field("tdata pad", 16'd0, 16'(out_tdata[23]));
      end
    end
  end

  initial begin
    dir_row_t   row;
    int         n, phase_len, phase_no, pick;
    logic [2:0] mode;
    logic [7:0] lim, pps;
    logic [15:0] rel;

    // shadow state at reset
    mode_r    = MODE_STD;
    limit_r   = 8'd4;
    reload_r  = 16'd500;
    pps_r     = 8'd8;
    m2_left   = 16'd500;
    ret_limit = 2'd2;
    lamp      = 1'b0;
    for (int i = 0; i < 5; i++) begin
      seq_st[i]    = (i >= 3) ? ACT_M1 : ACT_M3;
      m1_ph[i]     = (i >= 3) ? 5'd16 : ((i == 0) ? 5'd6 : 5'd0);
      m3_ph[i]     = (i >= 3) ? 5'd16 : 5'd0;
      pulse_cnt[i] = 8'd0;
      move_cnt[i]  = (i == 1 || i == 2) ? 8'd1 : 8'd0;
    end

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: normal mode walk, lamp and pulse gating, undefined modes,
    // fast advance, rewind, slow return, register extremes and zeros.
    dir_rows.push_back(mk_row(MODE_STD, 8'd4, 16'd500, 8'd8, 3'b000, 1'b1, 24'h000106));
    dir_rows.push_back(mk_row(MODE_STD, 8'd4, 16'd500, 8'd8, 3'b000, 1'b1, 24'h000146));
    dir_rows.push_back(mk_row(MODE_STD, 8'd4, 16'd500, 8'd8, 3'b001, 1'b1, 24'h200000));
    dir_rows.push_back(mk_row(MODE_STD, 8'd4, 16'd500, 8'd8, 3'b001, 1'b1, 24'h300000));
    dir_rows.push_back(mk_row(MODE_STD, 8'd4, 16'd500, 8'd8, 3'b100, 1'b1, 24'h340000));
    dir_rows.push_back(mk_row(MODE_UNUSED_LO, 8'd4, 16'd500, 8'd8, 3'b111, 1'b1, 24'h100000));
    dir_rows.push_back(mk_row(MODE_UNUSED_HI, 8'd4, 16'd500, 8'd8, 3'b010, 1'b1, 24'h100000));
    dir_rows.push_back(mk_row(MODE_FAST_ADV, 8'd4, 16'd500, 8'd8, 3'b000, 1'b1, 24'h100106));
    dir_rows.push_back(mk_row(MODE_FAST_ADV, 8'd4, 16'd500, 8'd8, 3'b001, 1'b1, 24'h500000));
    dir_rows.push_back(mk_row(MODE_FAST_ADV, 8'd4, 16'd500, 8'd8, 3'b100, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_FAST_ADV, 8'd4, 16'd500, 8'd8, 3'b010, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_STD, 8'd4, 16'd500, 8'd8, 3'b010, 1'b1, 24'h000000));
    dir_rows.push_back(mk_row(MODE_STD, 8'd4, 16'd500, 8'd8, 3'b000, 1'b1, 24'h000106));
    dir_rows.push_back(mk_row(MODE_REWIND, 8'd4, 16'd500, 8'd8, 3'b000, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_REWIND, 8'd4, 16'd500, 8'd8, 3'b001, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_REWIND, 8'd4, 16'd500, 8'd8, 3'b000, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_REWIND, 8'd4, 16'd500, 8'd8, 3'b010, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_SLOW_RET, 8'd4, 16'd500, 8'd8, 3'b000, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_SLOW_RET, 8'd4, 16'd500, 8'd8, 3'b110, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_SLOW_ADV, 8'd255, 16'hFFFF, 8'd255, 3'b000, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_SLOW_ADV, 8'd255, 16'hFFFF, 8'd255, 3'b001, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_SLOW_ADV, 8'd255, 16'hFFFF, 8'd255, 3'b000, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_STD, 8'd0, 16'd0, 8'd0, 3'b001, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_STD, 8'd0, 16'd0, 8'd0, 3'b100, 1'b0, 24'd0));
    dir_rows.push_back(mk_row(MODE_UNUSED_MID, 8'd0, 16'd0, 8'd0, 3'b101, 1'b1, 24'h100000));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.mode != mode_r || row.lim != limit_r || row.rel != reload_r || row.pps != pps_r)
        apply_setting(row.mode, row.lim, row.rel, row.pps, 1'b0);
      send_tick(row.tick, row.typed, row.want);
    end

    // The shared motor-2 countdown starts at 500; burn it down in slow advance
    // with every pulse a step so later phases see expiry and short reloads.
    apply_setting(MODE_SLOW_ADV, 8'd2, 16'd6, 8'd0, 1'b1);
    up_pct   = 25;
    down_pct = 0;
    req_pct  = 50;
    while (countdown_expiries == 0) random_tick();

    // Random phases: one setting each, switch densities per phase so the
    // sequences both run long and turn around often.
    phase_no = 0;
    while (random_ticks < RANDOM_TICKS) begin
      phase_no++;
      mode = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4))
                                        : 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      pick = $urandom_range(0, 7);
      lim  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
             (pick == 2) ? 8'($urandom) : 8'($urandom_range(1, 3));
      // Large reloads only where the countdown cannot expire, else it never comes back.
      pick = $urandom_range(0, 9);
      if (mode == MODE_FAST_ADV || mode == MODE_REWIND || mode > MODE_REWIND)
        rel = (pick < 4) ? 16'hFFFF : 16'($urandom);
      else
        rel = (pick == 0) ? 16'd0 : 16'($urandom_range(1, 12));
      pick = $urandom_range(0, 9);
      pps  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
             (pick == 2) ? 8'($urandom) : 8'($urandom_range(1, 3));
      apply_setting(mode, lim, rel, pps, 1'($urandom_range(0, 1)));

      pick     = $urandom_range(0, 3);
      up_pct   = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 15 : 50;
      pick     = $urandom_range(0, 3);
      down_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 15 : 50;
      req_pct  = $urandom_range(0, 1) ? 90 : 30;
      send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      if (phase_no == 1) begin
        // sender flat out while the receiver stalls
        send_idle_max = 0;
        long_hold_due = 1'b1;
      end
      phase_len = $urandom_range(20, 120);
      for (n = 0; n < phase_len; n++) random_tick();
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Ran %0d directed and %0d random ticks across %0d register settings.",
             dir_rows.size(), random_ticks, settings_applied);
    $display("Compared %0d results; %0d motor-2 countdown expiries, %0d long output stalls.",
             results_checked, countdown_expiries, long_holds);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tmls_pkg.sv
rtl/tmls_phase_step.sv
rtl/tmls_seq_core.sv
rtl/three_motor_limit_switch_sequencer.sv
dv/three_motor_limit_switch_sequencer_test.sv
